>>> rtl/pdfm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package pdfm_pkg;

    // Field widths.
    localparam int CMD_W  = 2;
    localparam int TS_W   = 32;
    localparam int ACC_W  = 48;
    localparam int TOT_W  = ACC_W + 1;
    localparam int PER_W  = 32;
    localparam int MINP_W = 16;
    localparam int DUTY_W = 14;
    localparam int FREQ_W = 27;

    // Scale factors applied before the divisions; they double as the clamp limits.
    localparam logic [DUTY_W-1:0] DUTY_SCALE = 14'd10000;
    localparam logic [FREQ_W-1:0] FREQ_SCALE = 27'd100000000;

    // Dividend width covers both scaled numerators.
    localparam int NUM_DUTY_W = ACC_W + DUTY_W;
    localparam int NUM_FREQ_W = PER_W + FREQ_W;
    localparam int NUM_W      = (NUM_DUTY_W > NUM_FREQ_W) ? NUM_DUTY_W : NUM_FREQ_W;
    localparam int CNT_W      = $clog2(NUM_W);

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_START = 2'd0;
    localparam logic [CMD_W-1:0] CMD_EDGE  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd2;

    // Register file.
    localparam int  ADDR_W = 3;
    localparam int  DATA_W = 32;
    localparam logic REG_MIN_PERIODS = 1'b0;
    localparam logic [MINP_W-1:0] MIN_PERIODS_RST = 16'd2;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

`default_nettype wire

>>> rtl/pdfm_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface pdfm_in_if;
    logic                         valid;
    logic                         ready;
    logic [pdfm_pkg::CMD_W-1:0]   cmd;
    logic [pdfm_pkg::TS_W-1:0]    timestamp_us;
    logic                         level;

    modport source (output valid, output cmd, output timestamp_us, output level, input ready);
    modport sink   (input valid, input cmd, input timestamp_us, input level, output ready);
endinterface

interface pdfm_out_if;
    logic                         valid;
    logic                         ready;
    logic                         valid_res;
    logic [pdfm_pkg::DUTY_W-1:0]  duty_hundredths;
    logic [pdfm_pkg::FREQ_W-1:0]  frequency_centihz;

    modport source (output valid, output valid_res, output duty_hundredths,
                    output frequency_centihz, input ready);
    modport sink   (input valid, input valid_res, input duty_hundredths,
                    input frequency_centihz, output ready);
endinterface

`default_nettype wire

>>> rtl/pdfm_apb.sv
`timescale 1ns / 1ps
`default_nettype none

module pdfm_apb (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pdfm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pdfm_pkg::DATA_W-1:0]   pwdata,
    output logic      [pdfm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready,
    output logic      [pdfm_pkg::MINP_W-1:0]   o_min_periods
);

    logic [pdfm_pkg::MINP_W-1:0] r_min_periods;
    logic                        reg_idx;

    assign reg_idx = paddr[2];
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_periods <= pdfm_pkg::MIN_PERIODS_RST;
        end else if (psel && penable && pwrite && pready
                     && reg_idx == pdfm_pkg::REG_MIN_PERIODS) begin
            r_min_periods <= pwdata[pdfm_pkg::MINP_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == pdfm_pkg::REG_MIN_PERIODS) begin
            prdata = pdfm_pkg::DATA_W'(r_min_periods);
        end
    end

    assign o_min_periods = r_min_periods;

endmodule

`default_nettype wire

>>> rtl/pdfm_div.sv
`timescale 1ns / 1ps
`default_nettype none

// Restoring divider, one quotient bit per cycle through a single subtractor.
module pdfm_div (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_start,
    input  wire logic [pdfm_pkg::NUM_W-1:0]    i_num,
    input  wire logic [pdfm_pkg::TOT_W-1:0]    i_den,
    output pdfm_pkg::t_div_stat                o_stat,
    output logic      [pdfm_pkg::NUM_W-1:0]    o_quo
);

    logic                          r_busy;
    logic                          r_done;
    logic [pdfm_pkg::CNT_W-1:0]    r_cnt;
    logic [pdfm_pkg::TOT_W-1:0]    r_rem;
    logic [pdfm_pkg::NUM_W-1:0]    r_quo;

    logic [pdfm_pkg::TOT_W:0]      rem_sh;
    logic [pdfm_pkg::TOT_W+1:0]    diff;
    logic                          borrow;

    assign rem_sh = {r_rem, r_quo[pdfm_pkg::NUM_W-1]};
    assign diff   = {1'b0, rem_sh} - {2'b00, i_den};
    assign borrow = diff[pdfm_pkg::TOT_W+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == pdfm_pkg::CNT_W'(pdfm_pkg::NUM_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_num;
        end else if (r_busy) begin
            if (!borrow) begin
                r_rem <= diff[pdfm_pkg::TOT_W-1:0];
            end else begin
                r_rem <= rem_sh[pdfm_pkg::TOT_W-1:0];
            end
            r_quo <= {r_quo[pdfm_pkg::NUM_W-2:0], !borrow};
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_quo       = r_quo;

endmodule

`default_nettype wire

>>> rtl/pwm_duty_frequency_meter.sv
// A start request is taken in idle. An edge request registers the time difference, then
// S_ACC does the saturating add into the high or low total. A read request reaches the
// result after two passes through the 62-step restoring divider; an invalid read skips
// the divider. One request is worked on at a time.
// Reset (synchronous, active low) clears all totals, the last edge time and level,
// the result valid flag, and sets min_periods to 2.
`timescale 1ns / 1ps
`default_nettype none

module pwm_duty_frequency_meter (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    pdfm_in_if.sink                            i_in,
    pdfm_out_if.source                         o_out,
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [pdfm_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [pdfm_pkg::DATA_W-1:0]   pwdata,
    output logic      [pdfm_pkg::DATA_W-1:0]   prdata,
    output logic                               pready
);

    // Sequencer states, one-hot.
    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_ACC    = 7'b0000010,
        S_START1 = 7'b0000100,
        S_DIV1   = 7'b0001000,
        S_START2 = 7'b0010000,
        S_DIV2   = 7'b0100000,
        S_OUT    = 7'b1000000
    } t_state;

    t_state r_state;
    t_state n_state;

    logic [pdfm_pkg::MINP_W-1:0]  min_periods;

    // Measurement state.
    logic [pdfm_pkg::TS_W-1:0]    r_last_time;
    logic                         r_prev_level;
    logic [pdfm_pkg::ACC_W-1:0]   r_high_total;
    logic [pdfm_pkg::ACC_W-1:0]   r_low_total;
    logic [pdfm_pkg::PER_W-1:0]   r_period_total;

    // Edge working registers.
    logic [pdfm_pkg::TS_W-1:0]    r_delta;
    logic                         r_new_level;

    // Read working registers.
    logic [pdfm_pkg::TOT_W-1:0]   r_total;
    logic [pdfm_pkg::NUM_W-1:0]   r_num_duty;
    logic [pdfm_pkg::NUM_W-1:0]   r_num_freq;
    logic                         r_inv;
    logic [pdfm_pkg::DUTY_W-1:0]  r_duty;
    logic [pdfm_pkg::FREQ_W-1:0]  r_freq;

    // Result register.
    logic                         r_out_valid;
    logic                         r_out_res;
    logic [pdfm_pkg::DUTY_W-1:0]  r_out_duty;
    logic [pdfm_pkg::FREQ_W-1:0]  r_out_freq;

    logic                         in_fire;
    logic                         div_start;
    logic [pdfm_pkg::NUM_W-1:0]   div_num;
    pdfm_pkg::t_div_stat          div_stat;
    logic [pdfm_pkg::NUM_W-1:0]   div_quo;

    logic [pdfm_pkg::ACC_W-1:0]   acc_sel;
    logic [pdfm_pkg::TOT_W-1:0]   acc_sum;
    logic [pdfm_pkg::ACC_W-1:0]   acc_new;
    logic                         out_load;

    pdfm_apb u_apb (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .o_min_periods (min_periods)
    );

    pdfm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (div_num),
        .i_den   (r_total),
        .o_stat  (div_stat),
        .o_quo   (div_quo)
    );

    // Requests are taken only while the sequencer is idle. The result register sits
    // between the sequencer and the output, so a waiting result does not hold up
    // start and edge requests; only a second read must wait for it to drain.
    assign i_in.ready = (r_state == S_IDLE);
    assign in_fire    = i_in.valid && i_in.ready;

    // The total charged by an edge is the one matching the level before the edge.
    // The sum is one bit wider, so its top bit flags overflow and the total sticks
    // at all ones.
    assign acc_sel = r_prev_level ? r_high_total : r_low_total;
    assign acc_sum = pdfm_pkg::TOT_W'(acc_sel) + pdfm_pkg::TOT_W'(r_delta);
    assign acc_new = acc_sum[pdfm_pkg::ACC_W] ? '1 : acc_sum[pdfm_pkg::ACC_W-1:0];

    // For a valid read, the divider is started once for the duty and once for the frequency.
    assign div_start = (r_state == S_START1 && !r_inv) || (r_state == S_START2);
    assign div_num   = (r_state == S_START2) ? r_num_freq : r_num_duty;

    // The result register is loaded once it is empty or being emptied this cycle.
    assign out_load  = (r_state == S_OUT) && (!r_out_valid || o_out.ready);

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    if (i_in.cmd == pdfm_pkg::CMD_EDGE) begin
                        n_state = S_ACC;
                    end else if (i_in.cmd == pdfm_pkg::CMD_READ) begin
                        n_state = S_START1;
                    end
                end
            end
            S_ACC: begin
                n_state = S_IDLE;
            end
            S_START1: begin
                n_state = r_inv ? S_OUT : S_DIV1;
            end
            S_DIV1: begin
                if (div_stat.done) begin
                    n_state = S_START2;
                end
            end
            S_START2: begin
                n_state = S_DIV2;
            end
            S_DIV2: begin
                if (div_stat.done) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control and measurement state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_last_time    <= '0;
            r_prev_level   <= 1'b0;
            r_high_total   <= '0;
            r_low_total    <= '0;
            r_period_total <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (in_fire) begin
                case (i_in.cmd)
                    pdfm_pkg::CMD_START: begin
                        r_prev_level <= i_in.level;
                        r_last_time  <= i_in.timestamp_us;
                    end
                    pdfm_pkg::CMD_EDGE: begin
                        r_last_time <= i_in.timestamp_us;
                    end
                    pdfm_pkg::CMD_READ: begin
                        // The totals are cleared as they are captured, valid or not.
                        r_high_total   <= '0;
                        r_low_total    <= '0;
                        r_period_total <= '0;
                    end
                    default: begin
                    end
                endcase
            end

            if (r_state == S_ACC) begin
                if (r_prev_level) begin
                    r_high_total <= acc_new;
                end else begin
                    r_low_total <= acc_new;
                end
                r_prev_level <= r_new_level;
                // A rise counts one period; the count sticks at its maximum.
                if (r_new_level && r_period_total != '1) begin
                    r_period_total <= r_period_total + 1'b1;
                end
            end

            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Working and payload registers.
    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            // Wrapping 32-bit difference from the previous event.
            r_delta     <= i_in.timestamp_us - r_last_time;
            r_new_level <= i_in.level;
            // Snapshot for a read: the exact sum of both totals, the two scaled
            // numerators, and whether the window is long enough to report.
            r_total    <= pdfm_pkg::TOT_W'(r_high_total) + pdfm_pkg::TOT_W'(r_low_total);
            r_num_duty <= pdfm_pkg::NUM_W'(r_high_total) * pdfm_pkg::NUM_W'(pdfm_pkg::DUTY_SCALE);
            r_num_freq <= pdfm_pkg::NUM_W'(r_period_total)
                          * pdfm_pkg::NUM_W'(pdfm_pkg::FREQ_SCALE);
            r_inv      <= (r_period_total <= pdfm_pkg::PER_W'(min_periods))
                          || (r_high_total == '0 && r_low_total == '0);
        end

        // Both quotients are clamped to their full-scale values.
        if (r_state == S_DIV1 && div_stat.done) begin
            if (div_quo > pdfm_pkg::NUM_W'(pdfm_pkg::DUTY_SCALE)) begin
                r_duty <= pdfm_pkg::DUTY_SCALE;
            end else begin
                r_duty <= div_quo[pdfm_pkg::DUTY_W-1:0];
            end
        end
        if (r_state == S_DIV2 && div_stat.done) begin
            if (div_quo > pdfm_pkg::NUM_W'(pdfm_pkg::FREQ_SCALE)) begin
                r_freq <= pdfm_pkg::FREQ_SCALE;
            end else begin
                r_freq <= div_quo[pdfm_pkg::FREQ_W-1:0];
            end
        end

        // An invalid read reports zeros in every field.
        if (out_load) begin
            r_out_res  <= !r_inv;
            r_out_duty <= r_inv ? '0 : r_duty;
            r_out_freq <= r_inv ? '0 : r_freq;
        end
    end

    assign o_out.valid             = r_out_valid;
    assign o_out.valid_res         = r_out_res;
    assign o_out.duty_hundredths   = r_out_duty;
    assign o_out.frequency_centihz = r_out_freq;

`ifndef NO_ASSERTIONS
    a_busy_not_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.busy |-> !i_in.ready)
        else $error("request accepted while the divider is busy");

    a_read_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && i_in.cmd == pdfm_pkg::CMD_READ)
        |=> (r_high_total == '0 && r_low_total == '0 && r_period_total == '0))
        else $error("totals not cleared by a read");

    a_duty_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_duty <= pdfm_pkg::DUTY_SCALE
                         && r_out_freq <= pdfm_pkg::FREQ_SCALE))
        else $error("result beyond full scale");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_res) |-> (r_out_duty == '0 && r_out_freq == '0))
        else $error("invalid result carries nonzero values");
`endif

endmodule

`default_nettype wire
